@@ hw/rtl/radix_page_table_map_unmap_defines.svh @@
// ----------------------------------------------------------------------------
// radix page table map/unmap assertion macros
// shared helpers for concurrent checks, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RADIX_PAGE_TABLE_MAP_UNMAP_DEFINES_SVH
`define RADIX_PAGE_TABLE_MAP_UNMAP_DEFINES_SVH

// property holds at every edge outside reset
`define RPTM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rptm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptm_pkg
// sizes, register codes and shared types of the radix page table engine
// ----------------------------------------------------------------------------
package rptm_pkg;

   localparam int TABLE_PAGES      = 64;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int IDX_W            = 9;
   localparam int PAGE_W           = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int NFP_W            = $clog2(TABLE_PAGES + 1);
   localparam int DEPTH            = TABLE_PAGES * ENTRIES_PER_PAGE;
   localparam int ADDR_W           = PAGE_W + IDX_W;

   localparam int VA_W       = 57;
   localparam int PA_W       = 52;
   localparam int FL_W       = 64;
   localparam int ENTRY_W    = 64;
   localparam int PAGE_SHIFT = 12;
   localparam int PFN_W      = ENTRY_W - PAGE_SHIFT;
   localparam int BASE_PFN_W = PA_W - PAGE_SHIFT;
   localparam int LEVEL_W    = 3;

   localparam logic [PAGE_SHIFT-1:0] LINK_BITS = 12'h007;

   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // register index is paddr bit 3 (8-byte stride)
   localparam logic REG_FIVE_LEVEL = 1'b0;
   localparam logic REG_TABLE_BASE = 1'b1;

   localparam logic KIND_MAP   = 1'b0;
   localparam logic KIND_UNMAP = 1'b1;

   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [ENTRY_W-1:0] wdata;
      logic               re;
      logic [ADDR_W-1:0]  raddr;
   } mem_req_type;

endpackage

@@ hw/rtl/rptm_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptm_store
// table page store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module rptm_store
   import rptm_pkg::*;
(
   input  logic               clock,
   input  mem_req_type        mem_req,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] store_mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= store_mem[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/radix_page_table_map_unmap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_page_table_map_unmap
// four/five level radix page table map and unmap engine with internal store
// ----------------------------------------------------------------------------
//  channel   ports    direction   contents
//  req       req_*    in          tuser kind; tdata va, pa, flags
//  rsp       rsp_*    out         tdata success, invalidate, invalidate_addr
//  csr       csr_*    in/out      five_level at 0x0, table_base at 0x8
//
//  after reset a clearing pass zeroes all TABLE_PAGES*512 entries of the store
//  with req_tready low; csr writes are taken during it.
//  one request at a time: each table level goes through a read and a check
//  state on the single store read port, with one shared 52-bit adder doing
//  link translation or link creation; the leaf of a map is written in its
//  read state without a check, and a walk ends early on a failure.
//  the result sits in an output register; a new request is accepted while it
//  waits, the next result waits until it has been taken.
// ----------------------------------------------------------------------------
`include "radix_page_table_map_unmap_defines.svh"

module radix_page_table_map_unmap
   import rptm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: va[56:0], pa[108:57], flags[172:109], zero fill
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: kind[0]
   input  logic                  req_tuser,
   // rsp_tdata: success[0], invalidate[1], invalidate_addr[58:2], zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               kind_ff, kind_in;
   logic [VA_W-1:0]    va_ff, va_in;
   logic [PA_W-1:0]    pa_ff, pa_in;
   logic [FL_W-1:0]    fl_ff, fl_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [NFP_W-1:0]   nfp_ff, nfp_in;
   logic               ok_ff, ok_in;
   logic               inv_ff, inv_in;
   logic               five_level_ff, five_level_in;
   logic [PA_W-1:0]    table_base_ff, table_base_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_success_ff, rsp_success_in;
   logic               rsp_inv_ff, rsp_inv_in;
   logic [VA_W-1:0]    rsp_addr_ff, rsp_addr_in;

   mem_req_type        mem_req;
   logic [ENTRY_W-1:0] rd_data;

   logic               csr_write;
   logic               present;
   logic               alu_sub;
   logic [PFN_W-1:0]   alu_a, alu_b, alu_sum;
   logic               in_store;
   logic [IDX_W-1:0]   cur_idx;
   logic [ADDR_W-1:0]  cur_slot;
   logic [PFN_W-1:0]   base_pfn;

   rptm_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3])
         REG_FIVE_LEVEL: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, five_level_ff};
         REG_TABLE_BASE: csr_prdata = {{(CSR_DATA_W-PA_W){1'b0}}, table_base_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // shared adder: translate a link (entry pfn - base pfn) or form one
   // (base pfn + next free page)
   assign base_pfn = {{(PFN_W-BASE_PFN_W){1'b0}}, table_base_ff[PA_W-1:PAGE_SHIFT]};
   assign present  = rd_data[0];
   assign alu_sub  = present;
   assign alu_a    = present ? rd_data[ENTRY_W-1:PAGE_SHIFT] : base_pfn;
   assign alu_b    = present ? base_pfn : {{(PFN_W-NFP_W){1'b0}}, nfp_ff};
   assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(PFN_W-1){1'b0}}, alu_sub};
   assign in_store = alu_sum < PFN_W'(TABLE_PAGES);

   assign cur_idx  = va_ff[PAGE_SHIFT + IDX_W * level_ff +: IDX_W];
   assign cur_slot = {page_ff, cur_idx};

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      kind_in        = kind_ff;
      va_in          = va_ff;
      pa_in          = pa_ff;
      fl_in          = fl_ff;
      level_in       = level_ff;
      page_in        = page_ff;
      nfp_in         = nfp_ff;
      ok_in          = ok_ff;
      inv_in         = inv_ff;
      five_level_in  = five_level_ff;
      table_base_in  = table_base_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_success_in = rsp_success_ff;
      rsp_inv_in     = rsp_inv_ff;
      rsp_addr_in    = rsp_addr_ff;
      mem_req        = '0;
      req_tready     = 1'b0;

      if (csr_write) begin
         unique case (csr_paddr[3])
            REG_FIVE_LEVEL: five_level_in = csr_pwdata[0];
            REG_TABLE_BASE: table_base_in = csr_pwdata[PA_W-1:0];
            default:        five_level_in = five_level_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_addr_ff;
            mem_req.wdata = '0;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = req_tuser;
               va_in    = req_tdata[VA_W-1:0];
               pa_in    = req_tdata[VA_W+PA_W-1:VA_W];
               fl_in    = req_tdata[VA_W+PA_W+FL_W-1:VA_W+PA_W];
               level_in = five_level_ff ? LEVEL_W'(4) : LEVEL_W'(3);
               page_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (level_ff == '0 && kind_ff == KIND_MAP) begin
               // leaf of a map is written without looking at it
               mem_req.we    = 1'b1;
               mem_req.waddr = cur_slot;
               mem_req.wdata = {{(ENTRY_W-PA_W){1'b0}}, pa_ff} | fl_ff;
               ok_in         = 1'b1;
               inv_in        = 1'b0;
               state_in      = ST_DONE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = cur_slot;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ok_in  = 1'b0;
            inv_in = 1'b0;
            if (level_ff == '0) begin
               // unmap leaf
               if (present) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cur_slot;
                  mem_req.wdata = '0;
                  ok_in         = 1'b1;
                  inv_in        = 1'b1;
               end
               state_in = ST_DONE;
            end else if (present) begin
               if (in_store) begin
                  page_in  = alu_sum[PAGE_W-1:0];
                  level_in = level_ff - 1'b1;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (kind_ff == KIND_UNMAP || nfp_ff == NFP_W'(TABLE_PAGES)) begin
               state_in = ST_DONE;
            end else begin
               // allocate the next free page and link it
               mem_req.we    = 1'b1;
               mem_req.waddr = cur_slot;
               mem_req.wdata = {alu_sum, LINK_BITS};
               page_in       = nfp_ff[PAGE_W-1:0];
               nfp_in        = nfp_ff + 1'b1;
               level_in      = level_ff - 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = ok_ff;
               rsp_inv_in     = inv_ff;
               rsp_addr_in    = inv_ff ? va_ff : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         nfp_ff        <= NFP_W'(1);
         five_level_ff <= 1'b1;
         table_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         nfp_ff        <= nfp_in;
         five_level_ff <= five_level_in;
         table_base_ff <= table_base_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      va_ff          <= va_in;
      pa_ff          <= pa_in;
      fl_ff          <= fl_in;
      level_ff       <= level_in;
      page_ff        <= page_in;
      ok_ff          <= ok_in;
      inv_ff         <= inv_in;
      rsp_success_ff <= rsp_success_in;
      rsp_inv_ff     <= rsp_inv_in;
      rsp_addr_ff    <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-VA_W-2){1'b0}}, rsp_addr_ff, rsp_inv_ff, rsp_success_ff};

   `RPTM_ASSERT(a_no_read_write_overlap, !(mem_req.we && mem_req.re), "store read and write overlap")
   `RPTM_ASSERT(a_free_page_bound, nfp_ff <= NFP_W'(TABLE_PAGES), "free page count past store size")
   `RPTM_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "ready after accept")
   `RPTM_ASSERT(a_invalidate_needs_success, !rsp_tvalid || !rsp_inv_ff || rsp_success_ff, "invalidate without success")

endmodule

@@ test/radix_page_table_map_unmap_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_page_table_map_unmap_test
// self-checking bench for the page table map/unmap engine: in the stall phases
// requests get random gaps on the req stream and the rsp side stalls at random.
// A mirror of the table store walks every accepted request and the outcome
// it predicts is compared field by field with each rsp transfer. Phases
// switch between four and five levels and move table_base to break links.
// ----------------------------------------------------------------------------
module radix_page_table_map_unmap_test
   import rptm_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 150000;
   localparam int MAX_REPORTS    = 100;

   typedef struct packed {
      logic            success;
      logic            invalidate;
      logic [VA_W-1:0] inval_addr;
   } walk_outcome_type;

   // mirror of the table store and the two registers
   class pte_scoreboard;
      logic [ENTRY_W-1:0] entries [DEPTH];
      int unsigned        next_page;
      logic               five_levels;
      logic [PA_W-1:0]    base_reg;
      walk_outcome_type   outcomes[$];
      int                 errors;

      function new();
         foreach (entries[i]) entries[i] = '0;
         next_page   = 1;
         five_levels = 1'b1;
         base_reg    = '0;
         errors      = 0;
      endfunction

      function void set_register(logic which, logic [CSR_DATA_W-1:0] value);
         if (which == REG_FIVE_LEVEL) five_levels = value[0];
         else base_reg = value[PA_W-1:0];
      endfunction

      function logic [ENTRY_W-1:0] base_page_addr();
         return {12'b0, base_reg[PA_W-1:PAGE_SHIFT], 12'b0};
      endfunction

      function bit follow(int unsigned page, int unsigned idx, bit grow,
                          output int unsigned child);
         logic [ENTRY_W-1:0] e;
         logic [ENTRY_W-1:0] off;
         e = entries[page * ENTRIES_PER_PAGE + idx];
         child = 0;
         if (e[0]) begin
            // link is translated with whatever base is current now
            off = {e[ENTRY_W-1:PAGE_SHIFT], 12'b0} - base_page_addr();
            if ((off >> PAGE_SHIFT) >= TABLE_PAGES) return 1'b0;
            child = int'(off >> PAGE_SHIFT);
            return 1'b1;
         end
         if (!grow || next_page >= TABLE_PAGES) return 1'b0;
         entries[page * ENTRIES_PER_PAGE + idx] =
            (base_page_addr() + (64'(next_page) << PAGE_SHIFT)) | 64'(LINK_BITS);
         child = next_page;
         next_page++;
         return 1'b1;
      endfunction

      function void note_request(logic kind, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                 logic [FL_W-1:0] fl);
         walk_outcome_type r;
         int unsigned      page;
         int unsigned      child;
         int unsigned      leaf;
         bit               ok;
         logic [VA_W-1:0]  shifted;
         r    = '0;
         page = 0;
         ok   = 1'b1;
         for (int lvl = five_levels ? 4 : 3; lvl >= 1; lvl--) begin
            shifted = va >> (PAGE_SHIFT + IDX_W * lvl);
            if (!follow(page, int'(shifted[IDX_W-1:0]), kind == KIND_MAP, child)) begin
               ok = 1'b0;
               break;
            end
            page = child;
         end
         if (ok) begin
            leaf = page * ENTRIES_PER_PAGE + int'(va[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT]);
            if (kind == KIND_MAP) begin
               entries[leaf] = {12'b0, pa} | fl;
               r.success = 1'b1;
            end else if (entries[leaf][0]) begin
               entries[leaf] = '0;
               r.success     = 1'b1;
               r.invalidate  = 1'b1;
               r.inval_addr  = va;
            end
         end
         outcomes.push_back(r);
      endfunction

      task report(string msg);
         if (errors < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [RSP_DATA_W-1:0] d);
         walk_outcome_type e;
         if (outcomes.size() == 0) begin
            report("result transfer with no request waiting");
            return;
         end
         e = outcomes.pop_front();
         if (d[0] !== e.success)
            report($sformatf("success got %0b expected %0b", d[0], e.success));
         if (d[1] !== e.invalidate)
            report($sformatf("invalidate got %0b expected %0b", d[1], e.invalidate));
         if (d[VA_W+1:2] !== e.inval_addr)
            report($sformatf("invalidate_addr got %h expected %h", d[VA_W+1:2],
                             e.inval_addr));
      endtask

      function int pending_count();
         return outcomes.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pte_scoreboard   sb = new();
   bit              stalls_on = 1'b0;
   int              rsp_hold = 0;
   int              idle_cycles = 0;
   logic [VA_W-1:0] mapped_va[$];

   radix_page_table_map_unmap dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // results first: a result can never belong to the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[VA_W-1:0], req_tdata[VA_W+PA_W-1:VA_W],
                            req_tdata[VA_W+PA_W+FL_W-1:VA_W+PA_W]);
      end
   end

   // receiver stalls in random bursts while stalls are on
   always @(posedge clock) begin
      if (rsp_hold > 0 && stalls_on) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
         rsp_hold   <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_hold   <= 0;
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("radix_page_table_map_unmap verification failed");
         $finish;
      end
   end

   task automatic csr_write(input logic which, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(which, value);
   endtask

   task automatic send_request(input logic kind, input logic [VA_W-1:0] va,
                               input logic [PA_W-1:0] pa, input logic [FL_W-1:0] fl);
      int gap;
      gap = (stalls_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, fl, pa, va};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_MAP) begin
         mapped_va.push_back(va);
         if (mapped_va.size() > 48) void'(mapped_va.pop_front());
      end
   endtask

   // wait out every outstanding walk before touching the registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return IDX_W'($urandom_range(1, 3));
         default: return IDX_W'($urandom_range(0, 511));
      endcase
   endfunction

   task automatic random_phase(input int count);
      logic            kind;
      logic [VA_W-1:0] va;
      logic [PA_W-1:0] pa;
      logic [FL_W-1:0] fl;
      int              r;
      repeat (count) begin
         kind = ($urandom_range(0, 1) == 0) ? KIND_MAP : KIND_UNMAP;
         r    = $urandom_range(0, 9);
         if (r < 5 && mapped_va.size() > 0) begin
            va = mapped_va[$urandom_range(0, mapped_va.size() - 1)];
            // neighbor leaf on an existing path
            if (r == 4) va[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT] = IDX_W'($urandom_range(0, 511));
         end else if (r < 9) begin
            va = {pick_index(), pick_index(), pick_index(), pick_index(),
                  IDX_W'($urandom_range(0, 511)), 12'($urandom_range(0, 4095))};
         end else begin
            va = VA_W'({$urandom, $urandom});
         end
         pa = PA_W'({$urandom, $urandom});
         fl = {$urandom, $urandom};
         if ($urandom_range(0, 4) != 0) fl[0] = 1'b1;
         send_request(kind, va, pa, fl);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = KIND_MAP;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers are taken while the store is being cleared
      csr_write(REG_FIVE_LEVEL, 64'h1);
      csr_write(REG_TABLE_BASE, 64'h0);

      // directed: five levels, base zero
      send_request(KIND_MAP,   '0, '0, 64'h1);
      send_request(KIND_UNMAP, '0, '0, '0);
      send_request(KIND_UNMAP, '0, '0, '0);
      send_request(KIND_UNMAP, VA_W'(5) << 48, '0, '0);
      send_request(KIND_MAP,   '1, '1, '1);
      send_request(KIND_UNMAP, '1, '0, '0);
      // leaf written without the present bit
      send_request(KIND_MAP,   VA_W'(1) << 12, PA_W'(52'h0_0ABC_DE00_0000), '0);
      send_request(KIND_UNMAP, VA_W'(1) << 12, '0, '0);
      // present bit coming from the physical address itself
      send_request(KIND_MAP,   VA_W'(1) << 12, PA_W'(1), '0);
      send_request(KIND_UNMAP, VA_W'(1) << 12, '0, '0);
      send_request(KIND_MAP,   VA_W'(2) << 12, PA_W'(52'h1_2345_6789_A000),
                   64'h8000_0000_0000_0001);
      send_request(KIND_MAP,   VA_W'(2) << 12, PA_W'(52'h0_0000_0004_3000), 64'h3);
      send_request(KIND_UNMAP, VA_W'(2) << 12, '0, '0);
      send_request(KIND_MAP,   VA_W'(1) << 48, PA_W'(52'hF_0000_0000_0000), 64'h7);
      send_request(KIND_UNMAP, (VA_W'(1) << 48) | (VA_W'(1) << 39), '0, '0);
      drain();

      // four levels: the top field is ignored
      csr_write(REG_FIVE_LEVEL, 64'hFFFF_FFFF_FFFF_FFFE);
      send_request(KIND_MAP,   '0, PA_W'(52'h0_0000_0000_5000), 64'h1);
      send_request(KIND_UNMAP, VA_W'(9'h1FF) << 48, '0, '0);
      send_request(KIND_UNMAP, VA_W'(9'h1FF) << 48, '0, '0);
      drain();

      // moved base: old links point outside the store, fresh ones use the new base
      csr_write(REG_FIVE_LEVEL, 64'h1);
      csr_write(REG_TABLE_BASE, '1);
      send_request(KIND_MAP,   '0, '0, 64'h1);
      send_request(KIND_UNMAP, VA_W'(1) << 48, '0, '0);
      send_request(KIND_MAP,   VA_W'(7) << 48, PA_W'(52'h0_0000_0000_9000), 64'h1);
      send_request(KIND_UNMAP, VA_W'(7) << 48, '0, '0);
      drain();
      csr_write(REG_TABLE_BASE, 64'h0);
      send_request(KIND_MAP,   VA_W'(7) << 48, '0, 64'h1);
      send_request(KIND_UNMAP, '0, '0, '0);
      drain();

      stalls_on = 1'b1;
      random_phase(250);
      drain();

      stalls_on = 1'b0;
      csr_write(REG_FIVE_LEVEL, {$urandom, $urandom} & ~64'h1);
      random_phase(120);
      drain();

      stalls_on = 1'b1;
      csr_write(REG_FIVE_LEVEL, {$urandom, $urandom} | 64'h1);
      csr_write(REG_TABLE_BASE, {$urandom, $urandom});
      random_phase(120);
      drain();

      csr_write(REG_TABLE_BASE, {$urandom, 32'h0} & 64'hFFF0_0000_0000_0000);
      random_phase(180);
      drain();

      // last stretch runs without any idling
      stalls_on = 1'b0;
      csr_write(REG_FIVE_LEVEL, 64'h0);
      random_phase(150);
      drain();

      if (sb.errors == 0 && sb.pending_count() == 0)
         $display("radix_page_table_map_unmap verification clean");
      else
         $display("radix_page_table_map_unmap verification failed");
      $finish;
   end

endmodule

@@ radix_page_table_map_unmap.f @@
+incdir+hw/rtl
hw/rtl/rptm_pkg.sv
hw/rtl/rptm_store.sv
hw/rtl/radix_page_table_map_unmap.sv
test/radix_page_table_map_unmap_test.sv
